/* hdl/wfg_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wfg_pkg: shared types and constants of the waveform generator
// Holds the field widths, the status, mode and register index codes, the
// per-sample bookkeeping record and the quarter-sine table builder.
// ----------------------------------------------------------------------------
package wfg_pkg;

   localparam int SINE_TABLE_BITS = 10;
   localparam int SINE_SIZE       = 1 << SINE_TABLE_BITS;
   localparam int INDEX_BITS      = 20;
   localparam int COUNT_W         = 21;
   localparam int CSR_INDEX_W     = 3;
   localparam int CSR_DATA_W      = 32;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_LIMIT = 2'd1,
      STATUS_STEP  = 2'd2,
      STATUS_PAST  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      MODE_SINE     = 2'd0,
      MODE_TRIANGLE = 2'd1,
      MODE_SQUARE   = 2'd2
   } mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MODE   = 3'd0,
      CSR_STEP   = 3'd1,
      CSR_AMP    = 3'd2,
      CSR_OFFSET = 3'd3,
      CSR_LOWER  = 3'd4,
      CSR_UPPER  = 3'd5,
      CSR_MAXSTP = 3'd6,
      CSR_COUNT  = 3'd7
   } csr_index_type;

   // Bookkeeping that travels beside the datapath for each sample.
   typedef struct packed {
      logic [INDEX_BITS-1:0] sample_index;
      logic                  past;
      logic                  last_point;
      logic                  has_prev;
   } meta_type;

   typedef logic [15:0] sine_rom_type [SINE_SIZE];

   // Quarter sine in Q1.15 from a fixed-point Taylor series in Q30.
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      logic [63:0]  x;
      logic [63:0]  x2;
      logic [63:0]  term;
      logic [63:0]  sum;
      logic [63:0]  q;
      for (int i = 0; i < SINE_SIZE; i++) begin
         x    = (64'(i) * HALF_PI_Q30) >> SINE_TABLE_BITS;
         x2   = (x * x) >> 30;
         term = x;
         sum  = x;
         for (int k = 1; k < 20; k++) begin
            term = (term * x2) >> 30;
            term = term / 64'((2 * k) * (2 * k + 1));
            if ((k % 2) == 1) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
         q = (sum + 64'd16384) >> 15;
         if (q > 64'd32767) begin
            q = 64'd32767;
         end
         rom[i] = q[15:0];
      end
      return rom;
   endfunction

endpackage
`default_nettype wire

/* hdl/wfg_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wfg_if: request and response channels of the waveform generator
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface wfg_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [31:0] start_phase;

   modport source (output valid, output action, output start_phase, input ready);
   modport sink   (input valid, input action, input start_phase, output ready);
endinterface

interface wfg_rsp_if;
   import wfg_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [INDEX_BITS-1:0] sample_index;
   logic signed [31:0]    target;
   logic [1:0]            status;
   logic                  last_point;

   modport source (output valid, output sample_index, output target, output status,
                   output last_point, input ready);
   modport sink   (input valid, input sample_index, input target, input status,
                   input last_point, output ready);
endinterface
`default_nettype wire

/* hdl/wfg_sine_rom.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wfg_sine_rom: quarter-wave sine table
// Constant table with a registered read port and a read enable.
// ----------------------------------------------------------------------------
module wfg_sine_rom (
   input  wire logic                                clock,
   input  wire logic                                rd_en,
   input  wire logic [wfg_pkg::SINE_TABLE_BITS-1:0] rd_addr,
   output logic [15:0]                              rd_data
);
   import wfg_pkg::*;

   localparam sine_rom_type SINE_ROM = build_sine_rom();

   logic [15:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= SINE_ROM[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* hdl/wfg_wave.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wfg_wave: wave shape stage
// Turns a phase into the magnitude and sign of the Q1.15 wave value.
// ----------------------------------------------------------------------------
module wfg_wave (
   input  wire logic              clock,
   input  wire logic              load,
   input  wire logic [31:0]       phase,
   input  wire wfg_pkg::mode_type mode,
   output logic [15:0]            mag,
   output logic                   neg
);
   import wfg_pkg::*;

   logic [SINE_TABLE_BITS-1:0] tidx;
   logic [SINE_TABLE_BITS-1:0] rom_addr;
   logic [15:0]                rom_data;
   logic [32:0]                tri_v;
   logic [32:0]                tri_t;
   logic [16:0]                tri_w;
   logic [15:0]                alt_mag_in;
   logic                       use_rom_in;
   logic                       neg_in;
   logic [15:0]                alt_mag_ff;
   logic                       use_rom_ff;
   logic                       neg_ff;

   assign tidx     = phase[29 -: SINE_TABLE_BITS];
   // Odd quadrants read the table mirrored.
   assign rom_addr = phase[30] ? (~tidx + {{(SINE_TABLE_BITS-1){1'b0}}, 1'b1}) : tidx;

   wfg_sine_rom u_rom (
      .clock   (clock),
      .rd_en   (load),
      .rd_addr (rom_addr),
      .rd_data (rom_data)
   );

   always_comb begin
      if (phase < 32'h4000_0000) begin
         tri_v = {1'b0, phase};
      end else if (phase < 32'hC000_0000) begin
         tri_v = 33'h0_8000_0000 - {1'b0, phase};
      end else begin
         tri_v = {1'b0, phase} - 33'h1_0000_0000;
      end
      tri_t = tri_v + 33'h0_4000_0000;
      tri_w = tri_t[31:15];

      alt_mag_in = 16'd32768;
      use_rom_in = 1'b0;
      neg_in     = phase[31];
      case (mode)
         MODE_SINE: begin
            use_rom_in = !(phase[30] && (tidx == '0));
            alt_mag_in = 16'd32767;
            neg_in     = phase[31];
         end
         MODE_TRIANGLE: begin
            neg_in = tri_w < 17'd32768;
            if (neg_in) begin
               alt_mag_in = 16'(17'd32768 - tri_w);
            end else begin
               alt_mag_in = 16'(tri_w - 17'd32768);
            end
         end
         default: begin
            alt_mag_in = 16'd32768;
            neg_in     = phase[31];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (load) begin
         alt_mag_ff <= alt_mag_in;
         use_rom_ff <= use_rom_in;
         neg_ff     <= neg_in;
      end
   end

   assign mag = use_rom_ff ? rom_data : alt_mag_ff;
   assign neg = neg_ff;

endmodule
`default_nettype wire

/* hdl/wfg_scale.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wfg_scale: amplitude scaling and offset
// Three stages: multiply, round, then add the offset with saturation.
// ----------------------------------------------------------------------------
module wfg_scale (
   input  wire logic               clock,
   input  wire logic               load_mul,
   input  wire logic               load_rnd,
   input  wire logic               load_sum,
   input  wire logic [15:0]        mag,
   input  wire logic               neg,
   input  wire logic [30:0]        amplitude,
   input  wire logic signed [31:0] level_offset,
   output logic signed [31:0]      target
);
   import wfg_pkg::*;

   logic [46:0]        prod_ff;
   logic               neg3_ff;
   logic [47:0]        rnd_sum;
   logic [31:0]        r_ff;
   logic               neg4_ff;
   logic [33:0]        r_ext;
   logic [33:0]        total;
   logic signed [31:0] target_in;
   logic signed [31:0] target_ff;

   always_ff @(posedge clock) begin
      if (load_mul) begin
         prod_ff <= 47'(amplitude) * 47'(mag);
         neg3_ff <= neg;
      end
   end

   // Half-up rounding on the magnitude gives rounding away from zero.
   assign rnd_sum = {1'b0, prod_ff} + 48'd16384;

   always_ff @(posedge clock) begin
      if (load_rnd) begin
         r_ff    <= rnd_sum[46:15];
         neg4_ff <= neg3_ff;
      end
   end

   always_comb begin
      r_ext = {2'b00, r_ff};
      total = {{2{level_offset[31]}}, level_offset} + (neg4_ff ? (~r_ext + 34'd1) : r_ext);
      if ((total[33:31] == 3'b000) || (total[33:31] == 3'b111)) begin
         target_in = total[31:0];
      end else if (total[33]) begin
         target_in = 32'sh8000_0000;
      end else begin
         target_in = 32'sh7FFF_FFFF;
      end
   end

   always_ff @(posedge clock) begin
      if (load_sum) begin
         target_ff <= target_in;
      end
   end

   assign target = target_ff;

endmodule
`default_nettype wire

/* hdl/waveform_generator_with_limits.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// waveform_generator_with_limits: DDS trajectory generator with limit checks
// Produces one sine, triangle or square sample per request, scaled, offset,
// saturated to Q16.16 and flagged against limits, step size and length.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake          contents
//   req_bus   in         valid / ready      action, start_phase
//   rsp_bus   out        valid / ready      sample_index, target, status,
//                                           last_point
//   csr_*     in         csr_we (no ready)  csr_index, csr_wdata
//
// One request transfer gives exactly one response, once the response side
// is ready; a new request can be taken every cycle while there is room.
// The response passes through the six-register pipeline: request register, sine
// table read, multiply, rounding, offset add, and the check/output register.
// A stalled response only holds up the stages behind it: empty stages still
// fill, and req_bus.ready falls only when all six stages hold a sample.
// Synchronous active-high reset restores the register defaults and clears
// the phase, index and previous-sample state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module waveform_generator_with_limits (
   input  wire logic                            clock,
   input  wire logic                            reset,
   wfg_req_if.sink                              req_bus,
   wfg_rsp_if.source                            rsp_bus,
   input  wire logic                            csr_we,
   input  wire logic [wfg_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [wfg_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import wfg_pkg::*;

   // Configuration registers.
   mode_type           mode_ff;
   logic [30:0]        step_ff;
   logic [30:0]        amp_ff;
   logic signed [31:0] offset_ff;
   logic signed [31:0] lower_ff;
   logic signed [31:0] upper_ff;
   logic [30:0]        maxstep_ff;
   logic [COUNT_W-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_SINE;
         step_ff    <= 31'd10737418;
         amp_ff     <= 31'd65536;
         offset_ff  <= '0;
         lower_ff   <= '0;
         upper_ff   <= '0;
         maxstep_ff <= '0;
         count_ff   <= 21'd2001;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_MODE:   mode_ff    <= mode_type'(csr_wdata[1:0]);
            CSR_STEP:   step_ff    <= csr_wdata[30:0];
            CSR_AMP:    amp_ff     <= csr_wdata[30:0];
            CSR_OFFSET: offset_ff  <= csr_wdata;
            CSR_LOWER:  lower_ff   <= csr_wdata;
            CSR_UPPER:  upper_ff   <= csr_wdata;
            CSR_MAXSTP: maxstep_ff <= csr_wdata[30:0];
            CSR_COUNT:  count_ff   <= csr_wdata[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Pipeline flow control. Each stage loads when it is empty or when the
   // stage after it loads, so bubbles close up behind a stalled output.
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic ld1, ld2, ld3, ld4, ld5, ld6;
   logic req_xfer;

   assign ld6 = !v6_ff || rsp_bus.ready;
   assign ld5 = !v5_ff || ld6;
   assign ld4 = !v4_ff || ld5;
   assign ld3 = !v3_ff || ld4;
   assign ld2 = !v2_ff || ld3;
   assign ld1 = !v1_ff || ld2;

   assign req_bus.ready = ld1;
   assign req_xfer      = req_bus.valid && ld1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (ld1) v1_ff <= req_bus.valid;
         if (ld2) v2_ff <= v1_ff;
         if (ld3) v3_ff <= v2_ff;
         if (ld4) v4_ff <= v3_ff;
         if (ld5) v5_ff <= v4_ff;
         if (ld6) v6_ff <= v5_ff;
      end
   end

   // Trajectory state, advanced on each request transfer. A restart loads
   // the start phase, rewinds the index and forgets the previous sample.
   logic [31:0]         acc_ff, acc_in;
   logic [INDEX_BITS:0] nidx_ff, nidx_in;
   logic                hp_ff, hp_in;
   logic [31:0]         phase_sel;
   logic [INDEX_BITS:0] idx_sel;
   logic                hp_sel;
   logic                past_sel;
   meta_type            meta_in;

   always_comb begin
      phase_sel = req_bus.action ? req_bus.start_phase : acc_ff;
      idx_sel   = req_bus.action ? '0 : nidx_ff;
      hp_sel    = req_bus.action ? 1'b0 : hp_ff;
      // Past the end when the index reaches the point count or the index
      // field can no longer hold it.
      past_sel  = (32'(idx_sel) >= 32'(count_ff)) || idx_sel[INDEX_BITS];

      meta_in.past         = past_sel;
      meta_in.sample_index = past_sel ? '0 : idx_sel[INDEX_BITS-1:0];
      meta_in.last_point   = !past_sel && ((32'(idx_sel) + 32'd1) == 32'(count_ff));
      meta_in.has_prev     = hp_sel;

      acc_in  = phase_sel + {1'b0, step_ff};
      nidx_in = past_sel ? idx_sel : (idx_sel + {{INDEX_BITS{1'b0}}, 1'b1});
      hp_in   = past_sel ? hp_sel : 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         nidx_ff <= '0;
         hp_ff   <= 1'b0;
      end else if (req_xfer) begin
         acc_ff  <= acc_in;
         nidx_ff <= nidx_in;
         hp_ff   <= hp_in;
      end
   end

   // Stage 1: the request register holds the phase of this sample.
   logic [31:0] phase1_ff;
   meta_type    meta1_ff, meta2_ff, meta3_ff, meta4_ff, meta5_ff;

   always_ff @(posedge clock) begin
      if (ld1) begin
         phase1_ff <= phase_sel;
         meta1_ff  <= meta_in;
      end
      if (ld2) meta2_ff <= meta1_ff;
      if (ld3) meta3_ff <= meta2_ff;
      if (ld4) meta4_ff <= meta3_ff;
      if (ld5) meta5_ff <= meta4_ff;
   end

   // Stage 2: wave shape, including the registered sine table read.
   logic [15:0] wave_mag;
   logic        wave_neg;

   wfg_wave u_wave (
      .clock (clock),
      .load  (ld2),
      .phase (phase1_ff),
      .mode  (mode_ff),
      .mag   (wave_mag),
      .neg   (wave_neg)
   );

   // Stages 3 to 5: multiply, round, offset and saturate.
   logic signed [31:0] target5;

   wfg_scale u_scale (
      .clock        (clock),
      .load_mul     (ld3),
      .load_rnd     (ld4),
      .load_sum     (ld5),
      .mag          (wave_mag),
      .neg          (wave_neg),
      .amplitude    (amp_ff),
      .level_offset (offset_ff),
      .target       (target5)
   );

   // Stage 6: limit and step checks against the previous sample that was not past
   // the end. The previous target is updated as each such sample enters the
   // output register, so the next sample always sees its direct predecessor.
   logic signed [31:0] prev_ff, prev_in;
   logic [32:0]        diff;
   logic [32:0]        diff_abs;
   logic               lim_bad;
   logic               step_bad;
   status_type         status_in;
   logic               prev_upd;

   always_comb begin
      diff     = {target5[31], target5} - {prev_ff[31], prev_ff};
      diff_abs = diff[32] ? (~diff + 33'd1) : diff;
      lim_bad  = (target5 < lower_ff) || (target5 > upper_ff);
      step_bad = meta5_ff.has_prev && (diff_abs > {2'b00, maxstep_ff});

      if (meta5_ff.past) begin
         status_in = STATUS_PAST;
      end else if ((maxstep_ff != '0) && lim_bad) begin
         status_in = STATUS_LIMIT;
      end else if ((maxstep_ff != '0) && step_bad) begin
         status_in = STATUS_STEP;
      end else begin
         status_in = STATUS_OK;
      end

      prev_upd = ld6 && v5_ff && !meta5_ff.past;
      prev_in  = prev_upd ? target5 : prev_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
      end else begin
         prev_ff <= prev_in;
      end
   end

   // Output register.
   logic [INDEX_BITS-1:0] out_index_ff;
   logic signed [31:0]    out_target_ff;
   status_type            out_status_ff;
   logic                  out_last_ff;

   always_ff @(posedge clock) begin
      if (ld6) begin
         out_index_ff  <= meta5_ff.sample_index;
         out_target_ff <= target5;
         out_status_ff <= status_in;
         out_last_ff   <= meta5_ff.last_point;
      end
   end

   assign rsp_bus.valid        = v6_ff;
   assign rsp_bus.sample_index = out_index_ff;
   assign rsp_bus.target       = out_target_ff;
   assign rsp_bus.status       = out_status_ff;
   assign rsp_bus.last_point   = out_last_ff;

   // A past-end sample reports index zero and is never the last point.
   a_past_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && (rsp_bus.status == STATUS_PAST)) |->
         ((rsp_bus.sample_index == '0) && !rsp_bus.last_point))
      else $error("past-end sample carries an index or last-point flag");

   // After a restart transfer the index is either one or zero.
   a_restart_index: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_bus.action) |=> ((nidx_ff == '0) || (nidx_ff == 1)))
      else $error("index not rewound by restart");

   // Requests are refused only when every stage holds a sample behind a stall.
   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> (v1_ff && v2_ff && v3_ff && v4_ff && v5_ff && v6_ff
                          && !rsp_bus.ready))
      else $error("request side stalled with room in the pipeline");

   // Limit and step flags appear only with checking enabled.
   a_checks_enabled: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && ((rsp_bus.status == STATUS_STEP) ||
                         (rsp_bus.status == STATUS_LIMIT))) |-> (maxstep_ff != '0))
      else $error("check flag raised while checks are disabled");

endmodule
`default_nettype wire
